// ===== rtl/core/mandelbrot_escape_time_pixel_defines.svh =====
// Assertion macros shared by the escape-time pixel RTL.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MEPT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MEPT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mept_pkg.sv =====
// Shared types, constants and helper functions of the escape-time pixel block.
package mept_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int QUEUE_DEPTH    = 2;

   localparam int COORD_W = 32;
   localparam int STEP_W  = 31;
   localparam int CNT_W   = 16;
   localparam int CSTEP_W = 25;
   localparam int COLOR_W = 8;
   localparam int FRAC_W  = 28;
   localparam int PROD_W  = CNT_W + CSTEP_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [COORD_W-1:0] RST_ORIGIN_RE  = -32'sd536870912;
   localparam logic signed [COORD_W-1:0] RST_ORIGIN_IM  = 32'sd348966093;
   localparam logic [STEP_W-1:0]         RST_PIXEL_STEP = 31'd681574;
   localparam logic [CNT_W-1:0]          RST_MAX_ITER   = 16'd256;
   localparam logic [CSTEP_W-1:0]        RST_COLOR_STEP = 25'd65536;

   // Escape threshold 4.0 in the Q8.56 format of the squared magnitude.
   localparam logic [64:0] ESC_LIMIT = 65'd4 << 56;
   localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_RE  = 3'd0,
      CSR_ORIGIN_IM  = 3'd1,
      CSR_PIXEL_STEP = 3'd2,
      CSR_MAX_ITER   = 3'd3,
      CSR_COLOR_STEP = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_SCALE,
      ST_EMIT
   } core_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // Clamp a wide signed value into the signed Q4.28 coordinate range.
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return $signed(v[COORD_W-1:0]);
   endfunction

endpackage

// ===== rtl/core/mept_front.sv =====
// Front end: accepts pixel words and maps them to the complex point c.
module mept_front #(
   parameter int XW = 10,
   parameter int YW = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [XW-1:0]                         req_pixel_x,
   input  logic [YW-1:0]                         req_pixel_y,
   input  logic signed [mept_pkg::COORD_W-1:0]   origin_re,
   input  logic signed [mept_pkg::COORD_W-1:0]   origin_im,
   input  logic [mept_pkg::STEP_W-1:0]           pixel_step,
   input  mept_pkg::queue_stat_type              qstat,
   output logic                                  push,
   output logic [XW-1:0]                         push_x,
   output logic [YW-1:0]                         push_y,
   output logic signed [mept_pkg::COORD_W-1:0]   push_cr,
   output logic signed [mept_pkg::COORD_W-1:0]   push_ci
);
   import mept_pkg::*;

   logic          hold_valid_ff;
   logic [XW-1:0] hold_x_ff;
   logic [YW-1:0] hold_y_ff;

   logic [XW+STEP_W-1:0] prod_x;
   logic [YW+STEP_W-1:0] prod_y;
   logic signed [63:0]   cr_wide;
   logic signed [63:0]   ci_wide;

   assign push      = hold_valid_ff && !qstat.full;
   assign req_ready = !hold_valid_ff || !qstat.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         hold_valid_ff <= 1'b1;
      end else if (push) begin
         hold_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         hold_x_ff <= req_pixel_x;
         hold_y_ff <= req_pixel_y;
      end
   end

   // Exact coordinates in 64 bits, then clamped to Q4.28.
   assign prod_x  = hold_x_ff * pixel_step;
   assign prod_y  = hold_y_ff * pixel_step;
   assign cr_wide = 64'(origin_re) + $signed({{(64-XW-STEP_W){1'b0}}, prod_x});
   assign ci_wide = 64'(origin_im) - $signed({{(64-YW-STEP_W){1'b0}}, prod_y});

   assign push_x  = hold_x_ff;
   assign push_y  = hold_y_ff;
   assign push_cr = sat_coord(cr_wide);
   assign push_ci = sat_coord(ci_wide);

endmodule

// ===== rtl/core/mept_queue.sv =====
// Short first-in first-out queue between the front end and the iteration core.
`include "mandelbrot_escape_time_pixel_defines.svh"

module mept_queue #(
   parameter int DW    = 84,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [DW-1:0]            push_data,
   input  logic                     pop,
   output logic [DW-1:0]            pop_data,
   output mept_pkg::queue_stat_type stat
);
   import mept_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [CW-1:0] cnt_ff;

   assign stat.full  = (cnt_ff == CW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   `MEPT_ASSERT_IMP(a_q_no_overflow, push && !pop, !stat.full, "queue written while full")
   `MEPT_ASSERT_IMP(a_q_no_underflow, pop, !stat.empty, "queue read while empty")
   `MEPT_ASSERT_IMP(a_q_count_bound, 1'b1, cnt_ff <= CW'(DEPTH), "queue count beyond depth")

endmodule

// ===== rtl/core/mept_core.sv =====
// Iteration core: runs z = z*z + c for one point and forms the result word.
`include "mandelbrot_escape_time_pixel_defines.svh"

module mept_core #(
   parameter int XW = 10,
   parameter int YW = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mept_pkg::queue_stat_type            qstat,
   output logic                                pop,
   input  logic [XW-1:0]                       q_x,
   input  logic [YW-1:0]                       q_y,
   input  logic signed [mept_pkg::COORD_W-1:0] q_cr,
   input  logic signed [mept_pkg::COORD_W-1:0] q_ci,
   input  logic [mept_pkg::CNT_W-1:0]          max_iterations,
   input  logic [mept_pkg::CSTEP_W-1:0]        color_step,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [XW-1:0]                       rsp_out_x,
   output logic [YW-1:0]                       rsp_out_y,
   output logic [mept_pkg::CNT_W-1:0]          rsp_escape_count,
   output logic [mept_pkg::COLOR_W-1:0]        rsp_color_index
);
   import mept_pkg::*;

   core_state_type state_ff;
   core_state_type state_in;

   logic [XW-1:0]              x_ff;
   logic [YW-1:0]              y_ff;
   logic signed [COORD_W-1:0]  cr_ff;
   logic signed [COORD_W-1:0]  ci_ff;
   logic signed [COORD_W-1:0]  zr_ff;
   logic signed [COORD_W-1:0]  zi_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [63:0]                sr_ff;
   logic [63:0]                si_ff;
   logic signed [63:0]         xp_ff;
   logic [CNT_W-1:0]           esc_ff;
   logic [PROD_W-1:0]          prod_ff;

   logic                       out_valid_ff;
   logic [XW-1:0]              out_x_ff;
   logic [YW-1:0]              out_y_ff;
   logic [CNT_W-1:0]           out_cnt_ff;
   logic [COLOR_W-1:0]         out_color_ff;

   logic signed [63:0]         sq_r;
   logic signed [63:0]         sq_i;
   logic signed [63:0]         prod_ri;
   logic [64:0]                mag;
   logic                       escaped;
   logic signed [64:0]         diff;
   logic signed [64:0]         nr_wide;
   logic signed [63:0]         ni_wide;
   logic [PROD_W-17:0]         scaled;
   logic [COLOR_W-1:0]         color;
   logic                       out_load;

   // Three products of the current z, registered before the update step.
   assign sq_r    = zr_ff * zr_ff;
   assign sq_i    = zi_ff * zi_ff;
   assign prod_ri = zr_ff * zi_ff;

   // The squares of the current z serve both the escape test and the update.
   assign mag     = {1'b0, sr_ff} + {1'b0, si_ff};
   assign escaped = mag > ESC_LIMIT;
   assign diff    = $signed({1'b0, sr_ff}) - $signed({1'b0, si_ff});
   assign nr_wide = (diff >>> FRAC_W) + 65'(cr_ff);
   assign ni_wide = (xp_ff >>> (FRAC_W - 1)) + 64'(ci_ff);

   // Palette index: product over 2^16, at least one when escaped, capped.
   assign scaled = prod_ff[PROD_W-1:16];
   always_comb begin
      if (esc_ff == '0) begin
         color = '0;
      end else if (scaled == '0) begin
         color = COLOR_W'(1);
      end else if (scaled > {{(PROD_W-16-COLOR_W){1'b0}}, COLOR_MAX}) begin
         color = COLOR_MAX;
      end else begin
         color = scaled[COLOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (escaped || (cnt_ff == max_iterations)) begin
               state_in = ST_SCALE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_SCALE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         x_ff   <= q_x;
         y_ff   <= q_y;
         cr_ff  <= q_cr;
         ci_ff  <= q_ci;
         zr_ff  <= '0;
         zi_ff  <= '0;
         cnt_ff <= '0;
      end
      if (state_ff == ST_MUL) begin
         sr_ff <= sq_r;
         si_ff <= sq_i;
         xp_ff <= prod_ri;
      end
      if (state_ff == ST_UPD) begin
         if (escaped) begin
            esc_ff <= cnt_ff;
         end else if (cnt_ff == max_iterations) begin
            esc_ff <= '0;
         end else begin
            zr_ff  <= sat_coord(nr_wide[63:0]);
            zi_ff  <= sat_coord(ni_wide);
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
      if (state_ff == ST_SCALE) begin
         prod_ff <= esc_ff * color_step;
      end
      if (out_load) begin
         out_x_ff     <= x_ff;
         out_y_ff     <= y_ff;
         out_cnt_ff   <= esc_ff;
         out_color_ff <= color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_x        = out_x_ff;
   assign rsp_out_y        = out_y_ff;
   assign rsp_escape_count = out_cnt_ff;
   assign rsp_color_index  = out_color_ff;

   `MEPT_ASSERT_NXT(a_mul_then_upd, state_ff == ST_MUL, state_ff == ST_UPD, "multiply step not followed by update")
   `MEPT_ASSERT_IMP(a_bounded_dark, out_valid_ff && (out_cnt_ff == '0), out_color_ff == '0, "bounded point has a nonzero color")
   `MEPT_ASSERT_IMP(a_escaped_lit, out_valid_ff && (out_cnt_ff != '0), out_color_ff != '0, "escaped point has color zero")

endmodule

// ===== rtl/core/mandelbrot_escape_time_pixel.sv =====
// Top level of the escape-time pixel evaluator: registers, front end, queue and core.
//
//   Channel  Direction  Handshake            Word
//   req      in         req_valid/req_ready  pixel column and row
//   rsp      out        rsp_valid/rsp_ready  column, row, escape count, color index
//   csr      in         csr_we               register index and write data
//
// In the core a pixel runs the loop until its point escapes or max_iterations is reached;
// each iteration is one step in the three 32x32 multipliers and one step of update and
// escape test, and that loop sets the rate. The front end registers each accepted pixel
// ahead of the queue and overlaps with the core.
// Reset is synchronous and clears all control state; the registers return to their
// reset values and no clearing pass is needed.
// A two-word queue lets the front end keep accepting while the core works, and the
// output register lets the core start the next pixel while a result waits to be taken.
module mandelbrot_escape_time_pixel #(
   parameter int MAX_WIDTH  = mept_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mept_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [$clog2(MAX_WIDTH)-1:0]         req_pixel_x,
   input  logic [$clog2(MAX_HEIGHT)-1:0]        req_pixel_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [$clog2(MAX_WIDTH)-1:0]         rsp_out_x,
   output logic [$clog2(MAX_HEIGHT)-1:0]        rsp_out_y,
   output logic [mept_pkg::CNT_W-1:0]           rsp_escape_count,
   output logic [mept_pkg::COLOR_W-1:0]         rsp_color_index,
   input  logic                                 csr_we,
   input  logic [mept_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mept_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import mept_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int QW = XW + YW + 2 * COORD_W;

   // Configuration registers; the user writes them only while no pixel is in flight (the block does not enforce it).
   logic signed [COORD_W-1:0] origin_re_ff;
   logic signed [COORD_W-1:0] origin_im_ff;
   logic [STEP_W-1:0]         pixel_step_ff;
   logic [CNT_W-1:0]          max_iter_ff;
   logic [CSTEP_W-1:0]        color_step_ff;

   // Front end to queue.
   queue_stat_type            qstat;
   logic                      push;
   logic [XW-1:0]             push_x;
   logic [YW-1:0]             push_y;
   logic signed [COORD_W-1:0] push_cr;
   logic signed [COORD_W-1:0] push_ci;
   logic [QW-1:0]             push_data;

   // Queue to core.
   logic                      pop;
   logic [QW-1:0]             pop_data;
   logic [XW-1:0]             q_x;
   logic [YW-1:0]             q_y;
   logic signed [COORD_W-1:0] q_cr;
   logic signed [COORD_W-1:0] q_ci;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_re_ff  <= RST_ORIGIN_RE;
         origin_im_ff  <= RST_ORIGIN_IM;
         pixel_step_ff <= RST_PIXEL_STEP;
         max_iter_ff   <= RST_MAX_ITER;
         color_step_ff <= RST_COLOR_STEP;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_RE:  origin_re_ff  <= $signed(csr_wdata);
            CSR_ORIGIN_IM:  origin_im_ff  <= $signed(csr_wdata);
            CSR_PIXEL_STEP: pixel_step_ff <= csr_wdata[STEP_W-1:0];
            CSR_MAX_ITER:   max_iter_ff   <= csr_wdata[CNT_W-1:0];
            CSR_COLOR_STEP: color_step_ff <= csr_wdata[CSTEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The front end turns the pixel position into the point c.
   mept_front #(
      .XW (XW),
      .YW (YW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .origin_re   (origin_re_ff),
      .origin_im   (origin_im_ff),
      .pixel_step  (pixel_step_ff),
      .qstat       (qstat),
      .push        (push),
      .push_x      (push_x),
      .push_y      (push_y),
      .push_cr     (push_cr),
      .push_ci     (push_ci)
   );

   assign push_data = {push_x, push_y, push_cr, push_ci};

   mept_queue #(
      .DW    (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (qstat)
   );

   assign q_x  = pop_data[QW-1 -: XW];
   assign q_y  = pop_data[2*COORD_W +: YW];
   assign q_cr = $signed(pop_data[COORD_W +: COORD_W]);
   assign q_ci = $signed(pop_data[0 +: COORD_W]);

   // The core iterates one point at a time and holds the result word.
   mept_core #(
      .XW (XW),
      .YW (YW)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .qstat            (qstat),
      .pop              (pop),
      .q_x              (q_x),
      .q_y              (q_y),
      .q_cr             (q_cr),
      .q_ci             (q_ci),
      .max_iterations   (max_iter_ff),
      .color_step       (color_step_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_escape_count (rsp_escape_count),
      .rsp_color_index  (rsp_color_index)
   );

endmodule

// ===== tb/sv/mandelbrot_escape_time_pixel_tb.sv =====
// Self-checking testbench for the Mandelbrot escape-time pixel evaluator.
module mandelbrot_escape_time_pixel_tb;
   import mept_pkg::*;

   localparam int X_W = $clog2(DEF_MAX_WIDTH);
   localparam int Y_W = $clog2(DEF_MAX_HEIGHT);

   // A pixel that stays bounded at the largest iteration limit keeps the core busy through
   // every iteration with no word moving on either side. The watchdog allows several
   // times that run before it declares the block hung.
   localparam int unsigned IDLE_LIMIT = 4 * (2 * 65535 + 5);

   // Most of the pixels come from the random views.
   localparam int RANDOM_ITEMS  = 680;
   localparam int SETTLE_CYCLES = 8;

   localparam longint Q428_MAX = 64'sd2147483647;
   localparam longint Q428_MIN = -64'sd2147483648;

   // How the result side paces itself between long hold-offs.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PATTERN
   } stall_mode_type;

   // One result word as the block presents it.
   typedef struct packed {
      logic [X_W-1:0]     col;
      logic [Y_W-1:0]     row;
      logic [CNT_W-1:0]   count;
      logic [COLOR_W-1:0] color;
   } pixel_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [X_W-1:0]        req_pixel_x = '0;
   logic [Y_W-1:0]        req_pixel_y = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [X_W-1:0]        rsp_out_x;
   logic [Y_W-1:0]        rsp_out_y;
   logic [CNT_W-1:0]      rsp_escape_count;
   logic [COLOR_W-1:0]    rsp_color_index;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ORIGIN_RE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Our own copy of the view and palette registers, starting at their reset values.
   // It is only updated while the block is idle, so every accepted pixel is evaluated
   // against the same settings the block uses for it.
   logic signed [COORD_W-1:0] cfg_origin_re  = RST_ORIGIN_RE;
   logic signed [COORD_W-1:0] cfg_origin_im  = RST_ORIGIN_IM;
   logic [STEP_W-1:0]         cfg_pixel_step = RST_PIXEL_STEP;
   logic [CNT_W-1:0]          cfg_max_iter   = RST_MAX_ITER;
   logic [CSTEP_W-1:0]        cfg_color_step = RST_COLOR_STEP;

   // Results still owed by the block, oldest first.
   pixel_word_type pending_pixels[$];
   int             failures = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int             hold_request = 0;

   mandelbrot_escape_time_pixel u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_escape_count (rsp_escape_count),
      .rsp_color_index  (rsp_color_index),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   // Clamp an exact wide value into the signed Q4.28 range.
   function automatic logic signed [COORD_W-1:0] clamp_q428(input longint v);
      if (v > Q428_MAX) begin
         return Q428_MAX[COORD_W-1:0];
      end else if (v < Q428_MIN) begin
         return Q428_MIN[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
   endfunction

   // Escape-time evaluation of one pixel under the current view. The point c is formed
   // exactly and then clamped; each iteration forms the new z from exact 64-bit squares
   // and cross product, floor-shifted back to Q4.28, plus c, clamped again. The escape
   // test uses the exact 65-bit sum of squares against 4.0.
   function automatic pixel_word_type evaluate_pixel(input logic [X_W-1:0] px,
                                                     input logic [Y_W-1:0] py);
      longint         c_re;
      longint         c_im;
      longint         zr;
      longint         zi;
      longint         sq_re;
      longint         sq_im;
      longint         prod_ri;
      longint         scaled;
      logic [64:0]    mag;
      int unsigned    n;
      int unsigned    count;
      pixel_word_type w;
      c_re = clamp_q428(longint'(cfg_origin_re) + longint'(px) * longint'(cfg_pixel_step));
      c_im = clamp_q428(longint'(cfg_origin_im) - longint'(py) * longint'(cfg_pixel_step));
      zr = 0;
      zi = 0;
      count = 0;
      for (n = 0; n < cfg_max_iter; n++) begin
         sq_re = zr * zr;
         sq_im = zi * zi;
         prod_ri = zr * zi;
         zr = clamp_q428(((sq_re - sq_im) >>> FRAC_W) + c_re);
         zi = clamp_q428((prod_ri >>> (FRAC_W - 1)) + c_im);
         sq_re = zr * zr;
         sq_im = zi * zi;
         mag = {1'b0, sq_re} + {1'b0, sq_im};
         if (mag > ESC_LIMIT) begin
            count = n + 1;
            break;
         end
      end
      w.col   = px;
      w.row   = py;
      w.count = count[CNT_W-1:0];
      w.color = '0;
      // An escaped point always gets a palette entry of at least one, and the scaled
      // index saturates at the top of the palette.
      if (count != 0) begin
         scaled = (longint'(count) * longint'(cfg_color_step)) >>> 16;
         if (scaled < 1) begin
            w.color = 8'd1;
         end else if (scaled > longint'(COLOR_MAX)) begin
            w.color = COLOR_MAX;
         end else begin
            w.color = scaled[COLOR_W-1:0];
         end
      end
      return w;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // Every result word accepted by the receiver is matched against the oldest pixel
   // still owed. A word with nothing owed is a failure of its own.
   always @(posedge clock) begin : check_results
      pixel_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("result word for pixel (%0d, %0d) with no pixel outstanding",
                   rsp_out_x, rsp_out_y);
            failures++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("out_x", want.col, rsp_out_x);
            check_field("out_y", want.row, rsp_out_y);
            check_field("escape_count", want.count, rsp_escape_count);
            check_field("color_index", want.color, rsp_color_index);
         end
      end
   end

   // The receiver paces itself by the current stall mode. A long hold-off, when one is
   // requested, overrides the mode and is counted down here, one cycle per edge.
   always @(posedge clock) begin : receiver_pacing
      int hold_left;
      int pace_count;
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            STALL_RANDOM: begin
               rsp_ready <= ($urandom_range(0, 9) < 7);
            end
            STALL_PATTERN: begin
               rsp_ready <= ((pace_count % 11) >= 4);
               pace_count++;
            end
            default: begin
               rsp_ready <= 1'b1;
            end
         endcase
      end
   end

   // Any word moving on either channel shows the block is alive.
   always @(posedge clock) begin : watchdog
      int unsigned idle_cycles;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $error("no word accepted on either channel for %0d cycles", idle_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   // Offer one pixel and hold it until the block takes it. Valid is left high so that a
   // following pixel goes out in the very next cycle.
   task automatic send_pixel(input logic [X_W-1:0] px, input logic [Y_W-1:0] py);
      req_valid   <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      pending_pixels.push_back(evaluate_pixel(px, py));
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop offering and wait until every owed result has been taken.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_ORIGIN_RE:  cfg_origin_re  = value;
         CSR_ORIGIN_IM:  cfg_origin_im  = value;
         CSR_PIXEL_STEP: cfg_pixel_step = value[STEP_W-1:0];
         CSR_MAX_ITER:   cfg_max_iter   = value[CNT_W-1:0];
         CSR_COLOR_STEP: cfg_color_step = value[CSTEP_W-1:0];
         default: ;
      endcase
   endtask

   // Program a whole view: corner, pixel spacing, iteration limit and palette scale.
   // Only called while the block is idle.
   task automatic load_view(input logic [31:0] re, input logic [31:0] im,
                            input logic [31:0] step, input logic [15:0] iters,
                            input logic [31:0] cstep);
      write_reg(CSR_ORIGIN_RE, re);
      write_reg(CSR_ORIGIN_IM, im);
      write_reg(CSR_PIXEL_STEP, step);
      write_reg(CSR_MAX_ITER, {16'd0, iters});
      write_reg(CSR_COLOR_STEP, cstep);
      csr_we <= 1'b0;
   endtask

   // Send pixels in bursts of random length. Most bursts walk along a row like a real
   // frame scan; the rest scatter pixels over the whole coordinate range. A zero gap
   // limit keeps valid high the whole time.
   task automatic stream_pixels(input int count, input int gap_max);
      int             burst_left;
      bit             scan;
      logic [X_W-1:0] col;
      logic [Y_W-1:0] row;
      burst_left = 0;
      scan = 1'b0;
      col = '0;
      row = '0;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            if (i != 0 && gap_max != 0) begin
               pause_sender($urandom_range(1, gap_max));
            end
            burst_left = $urandom_range(1, 16);
            scan = ($urandom_range(0, 2) != 0);
            col = X_W'($urandom);
            row = Y_W'($urandom);
         end else if (scan) begin
            col = col + 1'b1;
         end else begin
            col = X_W'($urandom);
            row = Y_W'($urandom);
         end
         send_pixel(col, row);
         burst_left--;
      end
   endtask

   // The block comes out of reset with a view of the whole set; the corners of the
   // frame are sent without any register write.
   task automatic test_reset_view();
      stall_mode = STALL_PATTERN;
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd0, 10'd1023);
      wait_for_results();
   endtask

   // With an iteration limit of zero nothing runs and every pixel reads as bounded.
   task automatic test_zero_limit();
      stall_mode = STALL_RANDOM;
      load_view(RST_ORIGIN_RE, RST_ORIGIN_IM, {1'b0, RST_PIXEL_STEP}, 16'd0, 32'd65536);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd700, 10'd300);
      wait_for_results();
   endtask

   // Corners at the ends of the coordinate range with the widest spacing, so that both
   // the point itself and the first iterate run off the Q4.28 range and clamp.
   task automatic test_saturation();
      stall_mode = STALL_RANDOM;
      load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd8, 32'd65536);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1, 10'd1);
      wait_for_results();
      load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd8, 32'd65536);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      wait_for_results();
   endtask

   // Points near the neck of the set escape after a few dozen iterations. With the
   // largest palette scale their index saturates; with a scale of zero an escaped point
   // still gets the first palette entry.
   task automatic test_palette_extremes();
      stall_mode = STALL_NONE;
      load_view(-32'sd201326592, 32'sd26843546, 32'd4194304, 16'd300, 32'h01FF_FFFF);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd0, 10'd10);
      send_pixel(10'd64, 10'd64);
      wait_for_results();
      load_view(-32'sd201326592, 32'sd26843546, 32'd4194304, 16'd300, 32'd0);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd0, 10'd10);
      send_pixel(10'd64, 10'd64);
      wait_for_results();
   endtask

   // The largest iteration limit. The origin stays bounded and runs every iteration;
   // the other pixels escape quickly and queue up behind it.
   task automatic test_deep_iteration();
      stall_mode = STALL_PATTERN;
      load_view(32'd0, 32'd0, 32'h0100_0000, 16'hFFFF, 32'd256);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd40, 10'd0);
      send_pixel(10'd0, 10'd40);
      send_pixel(10'd16, 10'd0);
      wait_for_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering quick
   // pixels, so the queue and output register fill and the input stalls.
   task automatic test_backpressure();
      stall_mode = STALL_NONE;
      load_view(RST_ORIGIN_RE, RST_ORIGIN_IM, {1'b0, RST_PIXEL_STEP}, 16'd1, 32'd65536);
      hold_request = 400;
      stream_pixels(24, 0);
      wait_for_results();
   endtask

   // Random views. Most sit around the upper half of the set so that counts spread over
   // the whole iteration range; one in ten is raw noise on the corner and pixel spacing.
   task automatic test_random_views();
      int          sent;
      int          phase_items;
      logic [31:0] re;
      logic [31:0] im;
      logic [31:0] step;
      logic [31:0] cstep;
      logic [15:0] iters;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            re   = $urandom;
            im   = $urandom;
            step = $urandom;
         end else begin
            re   = -32'sd603979776 + $urandom_range(0, 402653184);
            im   = 32'sd134217728 + $urandom_range(0, 268435456);
            step = $urandom_range(131072, 1048576);
         end
         iters = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(49, 160))
                                             : 16'($urandom_range(1, 48));
         cstep = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32'h01FF_FFFF)
                                             : (32'd256 << 16) / iters;
         load_view(re, im, step, iters, cstep);
         stall_mode  = stall_mode_type'($urandom_range(0, 2));
         phase_items = $urandom_range(30, 70);
         stream_pixels(phase_items, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12));
         wait_for_results();
         sent += phase_items;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_view();
      test_zero_limit();
      test_saturation();
      test_palette_extremes();
      test_deep_iteration();
      test_backpressure();
      test_random_views();
      // Give a stray result word the time one more pixel would take to show up.
      repeat (2 * cfg_max_iter + 16) @(posedge clock);
      if (failures == 0 && pending_pixels.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
